[rtl/point_add_range_sum_tree_defines.svh]
// Assertion macros for the point-add range-sum tree.
`ifndef POINT_ADD_RANGE_SUM_TREE_DEFINES_SVH
`define POINT_ADD_RANGE_SUM_TREE_DEFINES_SVH

// Check a property on every rising clock edge outside reset.
`define PARS_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Check that a condition is followed by a result in the next cycle.
`define PARS_ASSERT_NEXT(label, pre, post, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) else $error(msg);

`endif

[rtl/pars_pkg.sv]
// Shared types and constants of the point-add range-sum tree.
`default_nettype none

package pars_pkg;

	localparam logic FUNC_ADD   = 1'b0;
	localparam logic FUNC_QUERY = 1'b1;

	localparam int POS_W = 11;
	localparam int AMT_W = 32;
	localparam int SUM_W = 64;

	typedef enum logic [3:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_ADD_RD,
		ST_ADD_WR,
		ST_Q_TEST,
		ST_Q_LACC,
		ST_Q_R,
		ST_Q_RACC,
		ST_Q_DONE
	} pars_state_t;

	typedef enum logic [1:0] {
		RD_NODE,
		RD_LEFT,
		RD_RIGHT
	} rd_sel_t;

	typedef struct packed {
		logic    clr_we;
		logic    in_rdy;
		logic    rd_en;
		rd_sel_t rd_sel;
		logic    add_wr;
		logic    l_acc;
		logic    r_dec;
		logic    r_acc;
		logic    shift;
		logic    res_load;
	} pars_cmd_t;

	typedef struct packed {
		logic clr_last;
		logic op_valid;
		logic op_func;
		logic add_ok;
		logic query_ok;
		logic node_root;
		logic l_lt_r;
		logic l_odd;
		logic r_odd;
		logic out_free;
	} pars_stat_t;

endpackage

`default_nettype wire

[rtl/pars_if.sv]
// Channel interfaces of the point-add range-sum tree.
`default_nettype none

interface pars_op_if;
	logic               valid;
	logic               ready;
	logic               func;
	logic [10:0]        position;
	logic signed [31:0] amount;
	logic [10:0]        range_low;
	logic [10:0]        range_high;

	modport source (output valid, func, position, amount, range_low, range_high, input ready);
	modport sink (input valid, func, position, amount, range_low, range_high, output ready);
endinterface

interface pars_res_if;
	logic               valid;
	logic               ready;
	logic signed [63:0] range_sum;
	logic               range_error;

	modport source (output valid, range_sum, range_error, input ready);
	modport sink (input valid, range_sum, range_error, output ready);
endinterface

interface pars_cfg_if;
	logic        valid;
	logic        ready;
	logic [10:0] data;

	modport source (output valid, data, input ready);
	modport sink (input valid, data, output ready);
endinterface

`default_nettype wire

[rtl/pars_ctrl.sv]
// Controller state machine of the point-add range-sum tree.
`default_nettype none

module pars_ctrl (
	input  wire                 clk,
	input  wire                 arst_n,
	input  pars_pkg::pars_stat_t stat,
	output pars_pkg::pars_cmd_t  cmd
);
	import pars_pkg::*;

	pars_state_t state_q;
	pars_state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_CLEAR: begin
				if (stat.clr_last) state_d = ST_IDLE;
			end
			ST_IDLE: begin
				if (stat.op_valid) begin
					if (stat.op_func == FUNC_ADD) begin
						state_d = stat.add_ok ? ST_ADD_RD : ST_IDLE;
					end else begin
						state_d = stat.query_ok ? ST_Q_TEST : ST_Q_DONE;
					end
				end
			end
			ST_ADD_RD: state_d = ST_ADD_WR;
			ST_ADD_WR: state_d = stat.node_root ? ST_IDLE : ST_ADD_RD;
			ST_Q_TEST: begin
				if (!stat.l_lt_r) state_d = ST_Q_DONE;
				else if (stat.l_odd) state_d = ST_Q_LACC;
				else state_d = ST_Q_R;
			end
			ST_Q_LACC: state_d = ST_Q_R;
			ST_Q_R: state_d = stat.r_odd ? ST_Q_RACC : ST_Q_TEST;
			ST_Q_RACC: state_d = ST_Q_TEST;
			ST_Q_DONE: begin
				if (stat.out_free) state_d = ST_IDLE;
			end
			default: state_d = ST_CLEAR;
		endcase
	end

	always_comb begin
		cmd = '0;
		cmd.rd_sel = RD_NODE;
		case (state_q)
			ST_CLEAR: cmd.clr_we = 1'b1;
			ST_IDLE: cmd.in_rdy = 1'b1;
			ST_ADD_RD: begin
				cmd.rd_en  = 1'b1;
				cmd.rd_sel = RD_NODE;
			end
			ST_ADD_WR: cmd.add_wr = 1'b1;
			ST_Q_TEST: begin
				if (stat.l_lt_r && stat.l_odd) begin
					cmd.rd_en  = 1'b1;
					cmd.rd_sel = RD_LEFT;
				end
			end
			ST_Q_LACC: cmd.l_acc = 1'b1;
			ST_Q_R: begin
				if (stat.r_odd) begin
					cmd.rd_en  = 1'b1;
					cmd.rd_sel = RD_RIGHT;
					cmd.r_dec  = 1'b1;
				end else begin
					cmd.shift = 1'b1;
				end
			end
			ST_Q_RACC: cmd.r_acc = 1'b1;
			ST_Q_DONE: cmd.res_load = stat.out_free;
			default: cmd = '0;
		endcase
	end

endmodule

`default_nettype wire

[rtl/pars_dp.sv]
// Datapath of the point-add range-sum tree: node memory, walk registers, result register.
`default_nettype none

module pars_dp #(
	parameter int MAX_ELEMENTS = 1024
) (
	input  wire                 clk,
	input  wire                 arst_n,
	pars_op_if.sink             op,
	pars_res_if.source          res,
	pars_cfg_if.sink            cfg,
	input  pars_pkg::pars_cmd_t  cmd,
	output pars_pkg::pars_stat_t stat
);
	import pars_pkg::*;

	localparam int DEPTH   = 2 * MAX_ELEMENTS;
	localparam int AW      = $clog2(DEPTH);
	localparam int TW      = AW + 1;
	localparam int EW      = (TW > POS_W + 1) ? TW : POS_W + 1;
	localparam int CNT_RST = (MAX_ELEMENTS < 1024) ? MAX_ELEMENTS : 1024;

	localparam logic [EW-1:0] MAX_E = EW'(MAX_ELEMENTS);

	logic [SUM_W-1:0] node_q [DEPTH];
	logic [SUM_W-1:0] rd_q;
	logic [AW-1:0]    clr_q;
	logic [AW-1:0]    i_q;
	logic [TW-1:0]    l_q;
	logic [TW-1:0]    r_q;
	logic [SUM_W-1:0] delta_q;
	logic [SUM_W-1:0] sum_q;
	logic             err_q;
	logic [POS_W-1:0] cnt_q;
	logic             out_valid_q;
	logic [SUM_W-1:0] out_sum_q;
	logic             out_err_q;

	logic [EW-1:0]    pos_e;
	logic [EW-1:0]    lo_e;
	logic [EW-1:0]    hi_e;
	logic [EW-1:0]    cnt_e;
	logic [EW-1:0]    cfg_e;
	logic [POS_W-1:0] cfg_nz;
	logic [TW-1:0]    r_m1;
	logic [AW-1:0]    rd_addr;
	logic             load;

	assign pos_e = EW'(op.position);
	assign lo_e  = EW'(op.range_low);
	assign hi_e  = EW'(op.range_high);
	assign cnt_e = EW'(cnt_q);
	assign r_m1  = r_q - TW'(1);
	assign load  = op.valid && op.ready;

	assign op.ready  = cmd.in_rdy;
	assign cfg.ready = 1'b1;

	assign stat.clr_last  = (clr_q == AW'(DEPTH - 1));
	assign stat.op_valid  = op.valid;
	assign stat.op_func   = op.func;
	assign stat.add_ok    = (op.position != '0) && (pos_e <= cnt_e) && (pos_e <= MAX_E);
	assign stat.query_ok  = (op.range_low != '0) && (hi_e <= cnt_e) && (hi_e <= MAX_E) &&
		(op.range_low <= op.range_high);
	assign stat.node_root = (i_q == AW'(1));
	assign stat.l_lt_r    = (l_q < r_q);
	assign stat.l_odd     = l_q[0];
	assign stat.r_odd     = r_q[0];
	assign stat.out_free  = !out_valid_q || res.ready;

	// Clamp the written count into 1..MAX_ELEMENTS.
	assign cfg_nz = (cfg.data == '0) ? POS_W'(1) : cfg.data;
	assign cfg_e  = EW'(cfg_nz);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= POS_W'(CNT_RST);
		end else if (cfg.valid && cfg.ready) begin
			cnt_q <= (cfg_e > MAX_E) ? POS_W'(MAX_ELEMENTS) : cfg_nz;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q <= '0;
		end else if (cmd.clr_we) begin
			clr_q <= clr_q + AW'(1);
		end
	end

	always_comb begin
		case (cmd.rd_sel)
			RD_NODE:  rd_addr = i_q;
			RD_LEFT:  rd_addr = l_q[AW-1:0];
			RD_RIGHT: rd_addr = r_m1[AW-1:0];
			default:  rd_addr = i_q;
		endcase
	end

	always_ff @(posedge clk) begin
		if (cmd.clr_we) begin
			node_q[clr_q] <= '0;
		end else if (cmd.add_wr) begin
			node_q[i_q] <= rd_q + delta_q;
		end
		if (cmd.rd_en) begin
			rd_q <= node_q[rd_addr];
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			i_q     <= AW'(MAX_E + pos_e - EW'(1));
			delta_q <= {{(SUM_W - AMT_W){op.amount[AMT_W-1]}}, op.amount};
			l_q     <= TW'(MAX_E + lo_e - EW'(1));
			r_q     <= TW'(MAX_E + hi_e);
			sum_q   <= '0;
			err_q   <= !stat.query_ok;
		end else begin
			if (cmd.add_wr) i_q <= i_q >> 1;
			if (cmd.l_acc) begin
				sum_q <= sum_q + rd_q;
				l_q   <= l_q + TW'(1);
			end
			if (cmd.r_dec) r_q <= r_m1;
			if (cmd.r_acc) begin
				sum_q <= sum_q + rd_q;
				l_q   <= l_q >> 1;
				r_q   <= r_q >> 1;
			end
			if (cmd.shift) begin
				l_q <= l_q >> 1;
				r_q <= r_q >> 1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.res_load) begin
			out_valid_q <= 1'b1;
		end else if (res.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.res_load) begin
			out_sum_q <= sum_q;
			out_err_q <= err_q;
		end
	end

	assign res.valid       = out_valid_q;
	assign res.range_sum   = out_sum_q;
	assign res.range_error = out_err_q;

endmodule

`default_nettype wire

[rtl/point_add_range_sum_tree.sv]
// Top level of the point-add range-sum tree.
// Usage:
//   op  - item channel. func 0 adds amount (sign-extended to 64 bits) to the
//         counter at position; func 1 asks for the sum over range_low..range_high.
//   res - one result item per query, none per add. A reversed or out-of-bounds
//         range returns range_sum 0 with range_error set.
//   cfg - writes element_count; 0 is stored as 1, values above MAX_ELEMENTS
//         are clamped. Always ready; write only while the block is idle.
// Operation: the tree lives in a single-port node memory with a registered
// read. An add is accepted, then reads and writes back one node per tree
// level from leaf to root. A query is accepted, then walks the left/right
// bounds level by level (test, optional left and right node reads, each
// accumulated), ends with a closing test and loads the result register; a
// rejected query skips the walk. Items are handled one at a time.
// Reset: every counter is zero. After reset a clearing pass writes zero into
// all 2*MAX_ELEMENTS nodes, one per cycle, while op is held not ready.
// Stall: results sit in an output register. New items are accepted while a
// result waits; a query that finishes while the register is still full holds
// until the receiver takes the waiting result.
`default_nettype none
`include "point_add_range_sum_tree_defines.svh"

module point_add_range_sum_tree #(
	parameter int MAX_ELEMENTS = 1024
) (
	input  wire        clk,
	input  wire        arst_n,
	pars_op_if.sink    op,
	pars_res_if.source res,
	pars_cfg_if.sink   cfg
);
	import pars_pkg::*;

	pars_cmd_t  cmd;
	pars_stat_t stat;

	// Sequencer: clear pass, leaf-to-root update walk, two-sided query walk.
	pars_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.stat   (stat),
		.cmd    (cmd)
	);

	// Node memory, walk registers, count register and result register.
	pars_dp #(
		.MAX_ELEMENTS (MAX_ELEMENTS)
	) u_dp (
		.clk    (clk),
		.arst_n (arst_n),
		.op     (op),
		.res    (res),
		.cfg    (cfg),
		.cmd    (cmd),
		.stat   (stat)
	);

	// A rejected query reports a zero sum.
	`PARS_ASSERT(a_err_zero, (res.valid && res.range_error) |-> (res.range_sum == '0), "error result with nonzero sum")
	// A new result appears only after the sequencer loaded one.
	`PARS_ASSERT(a_res_src, $rose(res.valid) |-> $past(cmd.res_load), "result without load")
	// An add item never causes a result in the following cycle.
	`PARS_ASSERT_NEXT(a_add_quiet, op.valid && op.ready && (op.func == FUNC_ADD), !$rose(res.valid), "add produced a result")
	// No item is taken while the node memory is being cleared.
	`PARS_ASSERT(a_clr_block, cmd.clr_we |-> !op.ready, "item accepted during clear")

endmodule

`default_nettype wire
